FILE: sv/sira_pkg.sv
// Shared constants, codes and controller/datapath command types for the
// shifting insert/remove array. No dependencies.
`timescale 1ns / 1ps

package sira_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Field widths of the request and response words
   localparam int ACT_W  = 3;
   localparam int LEN_W  = 5;
   localparam int WORD_W = 64;
   localparam int STAT_W = 2;
   localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [CMP_W-1:0]  cmp_type;
   typedef logic [ACT_W-1:0]  act_type;
   typedef logic [STAT_W-1:0] stat_code_type;
   typedef logic [WORD_W-1:0] word_type;

   localparam act_type ACT_INSERT = 3'd0;
   localparam act_type ACT_REMOVE = 3'd1;
   localparam act_type ACT_READ   = 3'd2;
   localparam act_type ACT_WRITE  = 3'd3;
   localparam act_type ACT_RESIZE = 3'd4;

   localparam stat_code_type ST_OK    = 2'd0;
   localparam stat_code_type ST_RANGE = 2'd1;
   localparam stat_code_type ST_FULL  = 2'd2;

   // Memory read address select
   localparam logic [1:0] RD_PREV = 2'd0;
   localparam logic [1:0] RD_NEXT = 2'd1;
   localparam logic [1:0] RD_POS  = 2'd2;

   // Memory write select
   localparam logic [1:0] WR_SHIFT = 2'd0;
   localparam logic [1:0] WR_WORD  = 2'd1;
   localparam logic [1:0] WR_ZERO  = 2'd2;

   // Length update
   localparam logic [1:0] LEN_KEEP = 2'd0;
   localparam logic [1:0] LEN_INC  = 2'd1;
   localparam logic [1:0] LEN_DEC  = 2'd2;
   localparam logic [1:0] LEN_SET  = 2'd3;

   typedef struct packed {
      logic          capture;
      logic          k_load_used;
      logic          k_load_pos;
      logic          k_inc;
      logic          k_dec;
      logic          rd_en;
      logic [1:0]    rd_sel;
      logic          wr_en;
      logic [1:0]    wr_sel;
      logic [1:0]    len_op;
      logic          set_status;
      stat_code_type status;
      logic          read_hit;
      logic          rsp_load;
   } sira_cmd_type;

   typedef struct packed {
      act_type action;
      logic    pos_gt_len;
      logic    pos_ge_len;
      logic    len_full;
      logic    len_zero;
      logic    newlen_gt_cap;
      logic    k_eq_pos;
      logic    rem_done;
      logic    k_ge_newlen;
      logic    rsp_free;
   } sira_stat_type;

endpackage

FILE: sv/sira_req_if.sv
// Request channel: valid/ready handshake carrying one array action.
// Depends on sira_pkg.
`timescale 1ns / 1ps

interface sira_req_if;
   logic                  valid;
   logic                  ready;
   sira_pkg::act_type     action;
   sira_pkg::len_type     position;
   sira_pkg::word_type    word;
   sira_pkg::len_type     new_length;

   modport source (output valid, action, position, word, new_length, input ready);
   modport sink   (input valid, action, position, word, new_length, output ready);
endinterface

FILE: sv/sira_rsp_if.sv
// Response channel: valid/ready handshake carrying one action result.
// Depends on sira_pkg.
`timescale 1ns / 1ps

interface sira_rsp_if;
   logic                     valid;
   logic                     ready;
   sira_pkg::word_type       read_word;
   sira_pkg::len_type        length;
   sira_pkg::stat_code_type  status;

   modport source (output valid, read_word, length, status, input ready);
   modport sink   (input valid, read_word, length, status, output ready);
endinterface

FILE: sv/sira_dpath.sv
// Datapath: request registers, entry memory, shift index, length and the
// response register. Driven by sira_ctrl through sira_pkg command types.
`timescale 1ns / 1ps

module sira_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  sira_pkg::sira_cmd_type  cmd,
   output sira_pkg::sira_stat_type stat,
   input  sira_pkg::act_type       req_action,
   input  sira_pkg::len_type       req_position,
   input  sira_pkg::word_type      req_word,
   input  sira_pkg::len_type       req_new_length,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output sira_pkg::word_type      rsp_read_word,
   output sira_pkg::len_type       rsp_length,
   output sira_pkg::stat_code_type rsp_status
);

   sira_pkg::word_type      mem [sira_pkg::CAPACITY];

   sira_pkg::act_type       action_ff;
   sira_pkg::len_type       pos_ff;
   sira_pkg::word_type      word_ff;
   sira_pkg::len_type       newlen_ff;
   sira_pkg::cnt_type       used_ff, used_in;
   sira_pkg::cnt_type       k_ff, k_in;
   sira_pkg::word_type      rdata_ff;
   sira_pkg::stat_code_type status_ff;
   logic                    hit_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   sira_pkg::word_type      rsp_word_ff;
   sira_pkg::len_type       rsp_len_ff;
   sira_pkg::stat_code_type rsp_status_ff;

   sira_pkg::cnt_type       k_prev, k_next;
   sira_pkg::idx_type       raddr, waddr;
   sira_pkg::word_type      wdata;
   sira_pkg::cmp_type       pos_c, used_c, newlen_c, k_c, k_next_c;

   assign k_prev   = k_ff - sira_pkg::cnt_type'(1);
   assign k_next   = k_ff + sira_pkg::cnt_type'(1);
   assign pos_c    = sira_pkg::cmp_type'(pos_ff);
   assign used_c   = sira_pkg::cmp_type'(used_ff);
   assign newlen_c = sira_pkg::cmp_type'(newlen_ff);
   assign k_c      = sira_pkg::cmp_type'(k_ff);
   assign k_next_c = sira_pkg::cmp_type'(k_next);

   always_comb begin
      stat.action        = action_ff;
      stat.pos_gt_len    = pos_c > used_c;
      stat.pos_ge_len    = pos_c >= used_c;
      stat.len_full      = used_c >= sira_pkg::cmp_type'(sira_pkg::CAPACITY);
      stat.len_zero      = used_ff == '0;
      stat.newlen_gt_cap = newlen_c > sira_pkg::cmp_type'(sira_pkg::CAPACITY);
      stat.k_eq_pos      = k_c == pos_c;
      stat.rem_done      = k_next_c >= used_c;
      stat.k_ge_newlen   = k_c >= newlen_c;
      stat.rsp_free      = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      unique case (cmd.rd_sel)
         sira_pkg::RD_PREV: raddr = sira_pkg::idx_type'(k_prev);
         sira_pkg::RD_NEXT: raddr = sira_pkg::idx_type'(k_next);
         default:           raddr = sira_pkg::idx_type'(pos_ff);
      endcase
      unique case (cmd.wr_sel)
         sira_pkg::WR_SHIFT: begin
            waddr = sira_pkg::idx_type'(k_ff);
            wdata = rdata_ff;
         end
         sira_pkg::WR_WORD: begin
            waddr = sira_pkg::idx_type'(pos_ff);
            wdata = word_ff;
         end
         default: begin
            waddr = sira_pkg::idx_type'(k_ff);
            wdata = '0;
         end
      endcase
   end

   // Entry memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_comb begin
      unique case (cmd.len_op)
         sira_pkg::LEN_INC: used_in = used_ff + sira_pkg::cnt_type'(1);
         sira_pkg::LEN_DEC: used_in = used_ff - sira_pkg::cnt_type'(1);
         sira_pkg::LEN_SET: used_in = sira_pkg::cnt_type'(newlen_ff);
         default:           used_in = used_ff;
      endcase

      priority if (cmd.k_load_used) begin
         k_in = used_ff;
      end else if (cmd.k_load_pos) begin
         k_in = sira_pkg::cnt_type'(pos_ff);
      end else if (cmd.k_inc) begin
         k_in = k_next;
      end else if (cmd.k_dec) begin
         k_in = k_prev;
      end else begin
         k_in = k_ff;
      end

      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (cmd.capture) begin
         action_ff <= req_action;
         pos_ff    <= req_position;
         word_ff   <= req_word;
         newlen_ff <= req_new_length;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
         hit_ff    <= cmd.read_hit;
      end
      if (cmd.rsp_load) begin
         rsp_word_ff   <= hit_ff ? rdata_ff : '0;
         rsp_len_ff    <= sira_pkg::len_type'(used_ff);
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_word = rsp_word_ff;
   assign rsp_length    = rsp_len_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

FILE: sv/sira_ctrl.sv
// Controller: sequences one action at a time over the datapath, reading and then
// writing each shifted entry. Depends on sira_pkg command and status types.
`timescale 1ns / 1ps

module sira_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sira_pkg::sira_stat_type stat,
   output sira_pkg::sira_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DECODE  = 3'd1;
   localparam logic [2:0] S_INS_CHK = 3'd2;
   localparam logic [2:0] S_INS_WR  = 3'd3;
   localparam logic [2:0] S_REM_CHK = 3'd4;
   localparam logic [2:0] S_REM_WR  = 3'd5;
   localparam logic [2:0] S_RSZ     = 3'd6;
   localparam logic [2:0] S_DONE    = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.set_status = 1'b1;
            cmd.status     = sira_pkg::ST_OK;
            state_in       = S_DONE;
            unique case (stat.action)
               sira_pkg::ACT_INSERT: begin
                  priority if (stat.pos_gt_len) begin
                     cmd.status = sira_pkg::ST_RANGE;
                  end else if (stat.len_full) begin
                     cmd.status = sira_pkg::ST_FULL;
                  end else begin
                     cmd.set_status  = 1'b0;
                     cmd.k_load_used = 1'b1;
                     state_in        = S_INS_CHK;
                  end
               end
               sira_pkg::ACT_REMOVE: begin
                  // empty array: nothing to remove, no error
                  priority if (stat.len_zero) begin
                     cmd.status = sira_pkg::ST_OK;
                  end else if (stat.pos_ge_len) begin
                     cmd.status = sira_pkg::ST_RANGE;
                  end else begin
                     cmd.set_status = 1'b0;
                     cmd.k_load_pos = 1'b1;
                     state_in       = S_REM_CHK;
                  end
               end
               sira_pkg::ACT_READ: begin
                  if (stat.pos_ge_len) begin
                     cmd.status = sira_pkg::ST_RANGE;
                  end else begin
                     cmd.rd_en    = 1'b1;
                     cmd.rd_sel   = sira_pkg::RD_POS;
                     cmd.read_hit = 1'b1;
                  end
               end
               sira_pkg::ACT_WRITE: begin
                  if (stat.pos_ge_len) begin
                     cmd.status = sira_pkg::ST_RANGE;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = sira_pkg::WR_WORD;
                  end
               end
               sira_pkg::ACT_RESIZE: begin
                  if (stat.newlen_gt_cap) begin
                     cmd.status = sira_pkg::ST_FULL;
                  end else begin
                     cmd.set_status  = 1'b0;
                     cmd.k_load_used = 1'b1;
                     state_in        = S_RSZ;
                  end
               end
               default: begin
                  cmd.status = sira_pkg::ST_OK;
               end
            endcase
         end
         S_INS_CHK: begin
            if (stat.k_eq_pos) begin
               cmd.wr_en      = 1'b1;
               cmd.wr_sel     = sira_pkg::WR_WORD;
               cmd.len_op     = sira_pkg::LEN_INC;
               cmd.set_status = 1'b1;
               cmd.status     = sira_pkg::ST_OK;
               state_in       = S_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = sira_pkg::RD_PREV;
               state_in   = S_INS_WR;
            end
         end
         S_INS_WR: begin
            // move entry k-1 up to k
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = sira_pkg::WR_SHIFT;
            cmd.k_dec  = 1'b1;
            state_in   = S_INS_CHK;
         end
         S_REM_CHK: begin
            if (stat.rem_done) begin
               cmd.len_op     = sira_pkg::LEN_DEC;
               cmd.set_status = 1'b1;
               cmd.status     = sira_pkg::ST_OK;
               state_in       = S_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = sira_pkg::RD_NEXT;
               state_in   = S_REM_WR;
            end
         end
         S_REM_WR: begin
            // move entry k+1 down to k
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = sira_pkg::WR_SHIFT;
            cmd.k_inc  = 1'b1;
            state_in   = S_REM_CHK;
         end
         S_RSZ: begin
            if (stat.k_ge_newlen) begin
               cmd.len_op     = sira_pkg::LEN_SET;
               cmd.set_status = 1'b1;
               cmd.status     = sira_pkg::ST_OK;
               state_in       = S_DONE;
            end else begin
               // zero fill newly exposed entries
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = sira_pkg::WR_ZERO;
               cmd.k_inc  = 1'b1;
            end
         end
         S_DONE: begin
            // hold until the response register is free
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/shifting_insert_remove_array.sv
// Shifting insert/remove array: a 16-entry ordered list of 64-bit words with
// insert, remove, read, write and resize actions, one response word per request.
// Timing: one request is worked at a time. Read, write, remove on an empty list,
// the unused action codes and any rejected action go through acceptance, decode
// and the load of the response register. Insert also shifts length - position
// entries up, remove shifts length - position - 1 entries down, and resize to a
// larger length zero fills new_length - length entries, one entry at a time. The
// entry memory read is registered, so each moved entry is read and then written
// in separate states. A new request is taken once the previous one has reached
// the response register, even if that response has not yet been taken; no
// clearing pass follows reset.
// Depends on sira_pkg, sira_req_if, sira_rsp_if, sira_ctrl and sira_dpath.
`timescale 1ns / 1ps

module shifting_insert_remove_array (
   input  logic       clock,
   input  logic       reset,
   sira_req_if.sink   req_ch,
   sira_rsp_if.source rsp_ch
);

   sira_pkg::sira_cmd_type  cmd;
   sira_pkg::sira_stat_type stat;

   sira_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sira_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_ch.action),
      .req_position   (req_ch.position),
      .req_word       (req_ch.word),
      .req_new_length (req_ch.new_length),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_read_word  (rsp_ch.read_word),
      .rsp_length     (rsp_ch.length),
      .rsp_status     (rsp_ch.status)
   );

endmodule

FILE: sv/sira_checker.sv
// Port-level checks for the shifting insert/remove array, attached to the
// top level by bind. Depends on sira_pkg.
`timescale 1ns / 1ps

module sira_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input sira_pkg::word_type      rsp_read_word,
   input sira_pkg::len_type       rsp_length,
   input sira_pkg::stat_code_type rsp_status
);

   // A stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Busy right after taking a request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in progress");

   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_length <= sira_pkg::len_type'(sira_pkg::CAPACITY)))
      else $error("reported length beyond capacity");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == sira_pkg::ST_OK || rsp_status == sira_pkg::ST_RANGE ||
                     rsp_status == sira_pkg::ST_FULL))
      else $error("undefined status code");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != sira_pkg::ST_OK |-> rsp_read_word == '0)
      else $error("nonzero read word on failed action");

endmodule

bind shifting_insert_remove_array sira_checker u_sira_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_read_word (rsp_ch.read_word),
   .rsp_length    (rsp_ch.length),
   .rsp_status    (rsp_ch.status)
);
